>>> rtl/core/idq_pkg.sv
// Shared constants, types and the address helper for the indexed deque engine.
package idq_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;

    localparam int AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SUM_W  = AW + 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int POS_W  = 6;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;
    localparam int ITEM_W = 32;
    localparam int ECNT_W = 7;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [STAT_W-1:0] t_status;
    typedef logic [AW-1:0]     t_addr;
    typedef logic [CNT_W-1:0]  t_count;

    localparam t_cmd CMD_APPEND_BACK = 3'd0;
    localparam t_cmd CMD_TAKE_BACK   = 3'd1;
    localparam t_cmd CMD_TAKE_FRONT  = 3'd2;
    localparam t_cmd CMD_READ_AT     = 3'd3;
    localparam t_cmd CMD_REMOVE_AT   = 3'd4;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    // Physical slot of a logical offset from the front, wrapping once.
    function automatic t_addr slot_of(input t_addr front, input t_addr offset);
        logic [SUM_W-1:0] s;
        s = {1'b0, front} + {1'b0, offset};
        if (s >= SUM_W'(CAPACITY)) begin
            s = s - SUM_W'(CAPACITY);
        end
        return s[AW-1:0];
    endfunction

endpackage

>>> rtl/core/idq_if.sv
// Request and response channel interfaces of the indexed deque engine.
interface idq_req_if;
    import idq_pkg::*;

    logic                valid;
    logic                ready;
    t_cmd                command;
    logic [ITEM_W-1:0]   item_data;
    logic [POS_W-1:0]    position;

    modport source (output valid, output command, output item_data, output position,
                    input ready);
    modport sink   (input valid, input command, input item_data, input position,
                    output ready);
endinterface

interface idq_rsp_if;
    import idq_pkg::*;

    logic                valid;
    logic                ready;
    logic [ITEM_W-1:0]   read_data;
    t_status             status;
    logic [ECNT_W-1:0]   entry_count;

    modport source (output valid, output read_data, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input read_data, input status, input entry_count,
                    output ready);
endinterface

>>> rtl/core/idq_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module idq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/indexed_deque_engine.sv
// Indexed deque engine: bounded double-ended queue with positional read and remove.
// Append and any refused request go straight to the output register; take back, take front
//   and read at position first read the memory word, and remove at position moves each
//   entry behind the gap one place forward, one entry moved per cycle in the shift state.
// A new request is taken only in the idle state, so a request is not taken before the last
//   one is done; a result that finds the output register busy waits in the done state.
// Reset (synchronous, active low) empties the list and clears the output valid flag; the
//   entry memory is not cleared and needs no clearing pass.
module indexed_deque_engine (
    input  logic       i_clk,
    input  logic       i_rst_n,
    idq_req_if.sink    i_req,
    idq_rsp_if.source  o_rsp
);
    import idq_pkg::*;

    // Controller states
    localparam logic [1:0] S_IDLE  = 2'd0;  // take a request
    localparam logic [1:0] S_RDATA = 2'd1;  // memory word arrives for take or read
    localparam logic [1:0] S_SHIFT = 2'd2;  // close the gap left by a removal
    localparam logic [1:0] S_DONE  = 2'd3;  // result waits for the output register

    logic [1:0]            r_state, n_state;
    t_addr                 r_front, n_front;
    t_count                r_count, n_count;
    t_addr                 r_wr_off, n_wr_off;     // destination offset of the next move
    logic [ITEM_W-1:0]     r_res_data, n_res_data;
    t_status               r_res_status, n_res_status;

    // Output register: parts the controller from the response channel
    logic                  r_out_valid, n_out_valid;
    logic [ITEM_W-1:0]     r_out_data, n_out_data;
    t_status               r_out_status, n_out_status;
    t_count                r_out_count, n_out_count;

    // Memory port
    logic                  ram_we;
    t_addr                 ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    t_addr                 ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic                  accept;
    logic                  out_free;
    logic                  fin;
    logic [ITEM_W-1:0]     fin_data;
    t_status               fin_status;
    logic [CMP_W-1:0]      pos_c;
    logic [CMP_W-1:0]      cnt_c;
    logic                  full;
    logic                  empty;

    idq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign pos_c       = CMP_W'(i_req.position);
    assign cnt_c       = CMP_W'(r_count);
    assign full        = (r_count == CNT_W'(CAPACITY));
    assign empty       = (r_count == '0);

    always_comb begin
        n_state      = r_state;
        n_front      = r_front;
        n_count      = r_count;
        n_wr_off     = r_wr_off;
        n_res_data   = r_res_data;
        n_res_status = r_res_status;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = '0;
        fin          = 1'b0;
        fin_data     = '0;
        fin_status   = ST_OK;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_req.command)
                        CMD_APPEND_BACK: begin
                            fin = 1'b1;
                            if (full) begin
                                fin_status = ST_FULL;
                            end else begin
                                // Write the new back entry right away
                                ram_we    = 1'b1;
                                ram_waddr = slot_of(r_front, AW'(r_count));
                                ram_wdata = DATA_WIDTH'(i_req.item_data);
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        CMD_TAKE_BACK: begin
                            if (empty) begin
                                fin        = 1'b1;
                                fin_status = ST_EMPTY;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = slot_of(r_front, AW'(r_count - CNT_W'(1)));
                                n_count   = r_count - CNT_W'(1);
                                n_state   = S_RDATA;
                            end
                        end
                        CMD_TAKE_FRONT: begin
                            if (empty) begin
                                fin        = 1'b1;
                                fin_status = ST_EMPTY;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = r_front;
                                n_front   = slot_of(r_front, AW'(1));
                                n_count   = r_count - CNT_W'(1);
                                n_state   = S_RDATA;
                            end
                        end
                        CMD_READ_AT: begin
                            if (pos_c >= cnt_c) begin
                                fin        = 1'b1;
                                fin_status = ST_EMPTY;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = slot_of(r_front, AW'(i_req.position));
                                n_state   = S_RDATA;
                            end
                        end
                        CMD_REMOVE_AT: begin
                            if (pos_c >= cnt_c) begin
                                fin        = 1'b1;
                                fin_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - CNT_W'(1);
                                if (pos_c + CMP_W'(1) == cnt_c) begin
                                    // Last entry: nothing behind it to move
                                    fin = 1'b1;
                                end else begin
                                    // Fetch the entry behind the gap
                                    ram_re    = 1'b1;
                                    ram_raddr = slot_of(r_front,
                                                        AW'(i_req.position) + AW'(1));
                                    n_wr_off  = AW'(i_req.position);
                                    n_state   = S_SHIFT;
                                end
                            end
                        end
                        default: begin
                            fin        = 1'b1;
                            fin_status = ST_EMPTY;
                        end
                    endcase
                end
            end
            S_RDATA: begin
                fin      = 1'b1;
                fin_data = ITEM_W'(ram_rdata);
            end
            S_SHIFT: begin
                // Move the fetched word one place forward; the next fetch runs two
                // places ahead of this write, so read and write never meet.
                ram_we    = 1'b1;
                ram_waddr = slot_of(r_front, r_wr_off);
                ram_wdata = ram_rdata;
                if (CNT_W'(r_wr_off) + CNT_W'(1) == r_count) begin
                    fin = 1'b1;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = slot_of(r_front, r_wr_off + AW'(2));
                    n_wr_off  = r_wr_off + AW'(1);
                end
            end
            S_DONE: begin
                fin        = 1'b1;
                fin_data   = r_res_data;
                fin_status = r_res_status;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Hand the result to the output register, or park it until there is room
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        if (fin) begin
            if (out_free) begin
                n_out_valid  = 1'b1;
                n_out_data   = fin_data;
                n_out_status = fin_status;
                n_out_count  = n_count;
                n_state      = S_IDLE;
            end else begin
                n_res_data   = fin_data;
                n_res_status = fin_status;
                n_state      = S_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_off     <= n_wr_off;
        r_res_data   <= n_res_data;
        r_res_status <= n_res_status;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_data   = r_out_data;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.entry_count = ECNT_W'(r_out_count);

    // The controller must never read and write the same entry in one cycle
    a_no_rw_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re && (ram_waddr == ram_raddr)))
        else $error("read and write hit the same entry");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (CNT_W'(r_wr_off) < r_count))
        else $error("shift destination beyond the list");

    a_shift_front_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |=> $stable(r_front))
        else $error("front moved during a removal");

    a_result_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin && !out_free) |=> (r_state == S_DONE))
        else $error("finished result dropped while output busy");

endmodule
